// ----- hw/rtl/lruk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lruk_pkg
// Shared types and codes for the LRU-K page replacer.
// ----------------------------------------------------------------------------
package lruk_pkg;

    localparam logic [1:0] OP_ACCESS = 2'd0;
    localparam logic [1:0] OP_SETEV  = 2'd1;
    localparam logic [1:0] OP_EVICT  = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NONE    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_UNTRACK = 3'd3;
    localparam logic [2:0] ST_CLKSAT  = 3'd4;

    localparam logic [3:0] K_RESET = 4'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] page_number;
        logic        evictable_flag;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] victim_page;
        logic [6:0]  evictable_count;
    } rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lru_k_page_replacer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_k_page_replacer_core
// LRU-K replacer: page table and timestamp history in synchronous memories.
// ----------------------------------------------------------------------------
// Each beat is handled on its own. Results go to an output register, so a
// waiting result does not block the next beat. Set evictable and remove look
// the page up by walking the page memory one entry per cycle; record access
// does the same and then writes the history. Evict reads the metadata, then
// the history, of each entry in turn, with a compare step for each evictable
// entry. The final state stalls only while the previous result beat is still
// waiting. There is no clearing pass: the valid and evictable bits are
// flip-flops cleared by reset.
module lru_k_page_replacer_core #(
    parameter int ENTRIES    = 64,
    parameter int MAX_K      = 8,
    parameter int CLOCK_BITS = 32
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_we,
    input  wire [3:0]              cfg_wdata,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire lruk_pkg::req_t    s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output lruk_pkg::rsp_t         m_data
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW = $clog2(MAX_K + 1);
    localparam int HW = IW + SW;
    localparam int NW = $clog2(ENTRIES + 1);
    localparam logic [CLOCK_BITS-1:0] CLK_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_LOOKW, S_DISP, S_HWR, S_EMETA, S_EHIST, S_ECMP, S_DONE
    } state_t;

    // memories
    logic [31:0]           page_mem [ENTRIES];
    logic [CW-1:0]         cnt_mem  [ENTRIES];
    logic [SW-1:0]         slot_mem [ENTRIES];
    logic [CLOCK_BITS-1:0] hist_mem [2**HW];

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] ev_reg;

    state_t                state_reg;
    logic [3:0]            k_reg;
    logic [CLOCK_BITS-1:0] clk_reg;
    logic [NW-1:0]         evtot_reg;
    lruk_pkg::req_t        req_reg;
    lruk_pkg::rsp_t        rsp_reg;
    logic [2:0]            st_reg;
    logic                  mv_reg;
    logic [IW:0]           idx_reg;
    logic [IW-1:0]         prev_reg;
    logic                  found_reg, free_ok_reg;
    logic [IW-1:0]         hit_reg, free_reg;
    logic                  best_ok_reg, best_cls_reg;
    logic [CLOCK_BITS-1:0] best_ts_reg;
    logic [IW-1:0]         best_reg;
    logic                  cls_reg;
    logic [IW-1:0]         cand_reg;
    logic                  cand_ok_reg;

    // memory read and write ports
    logic [IW-1:0]         pa;
    logic [31:0]           prd;
    logic [CW-1:0]         crd;
    logic [SW-1:0]         srd;
    logic [HW-1:0]         ha;
    logic [CLOCK_BITS-1:0] hrd;
    logic                  pwe, mwe, hwe;
    logic [IW-1:0]         mwa;
    logic [31:0]           pwd;
    logic [CW-1:0]         cwd;
    logic [SW-1:0]         swd;
    logic [HW-1:0]         hwa;
    logic [CLOCK_BITS-1:0] hwd;

    always_ff @(posedge aclk) begin
        if (pwe) page_mem[mwa] <= pwd;
        if (mwe) begin
            cnt_mem[mwa]  <= cwd;
            slot_mem[mwa] <= swd;
        end
        if (hwe) hist_mem[hwa] <= hwd;
        prd <= page_mem[pa];
        crd <= cnt_mem[pa];
        srd <= slot_mem[pa];
        hrd <= hist_mem[ha];
    end

    logic [3:0]    keff;
    logic [IW-1:0] idx;
    logic [IW-1:0] tgt;
    logic [CW-1:0] cnt_sat;
    logic [SW-1:0] ksl, rsl, nsl;
    logic [SW:0]   rsum;
    logic          infc, better;

    always_comb begin
        keff = (k_reg == 4'd0) ? 4'd1 : k_reg;
        if (32'(keff) > MAX_K) keff = 4'(MAX_K);
        idx  = idx_reg[IW-1:0];
        tgt  = found_reg ? hit_reg : free_reg;
        ksl  = (32'(keff) >= MAX_K) ? '0 : SW'(keff);
        rsum = {1'b0, srd} + (SW+1)'(MAX_K) - {1'b0, ksl};
        rsl  = (32'(rsum) >= MAX_K) ? SW'(32'(rsum) - MAX_K) : rsum[SW-1:0];
        if (MAX_K == 1) rsl = '0;
        infc = (32'(crd) < 32'(keff));
        nsl  = (32'(srd) + 1 >= MAX_K) ? '0 : SW'(srd + 1'b1);
        cnt_sat = (32'(crd) < MAX_K) ? CW'(crd + 1'b1) : crd;
        better = !best_ok_reg || (!cls_reg && best_cls_reg)
                 || ((cls_reg == best_cls_reg) && (hrd < best_ts_reg));
        pa  = idx;
        ha  = {cand_reg, (infc ? SW'(0) : rsl)};
        if (state_reg == S_DISP || state_reg == S_HWR) pa = tgt;
        if (state_reg == S_ECMP || state_reg == S_DONE) pa = best_reg;
        pwe = 1'b0; mwe = 1'b0; hwe = 1'b0;
        mwa = tgt; pwd = req_reg.page_number; cwd = '0; swd = '0;
        hwa = '0; hwd = clk_reg;
        if (state_reg == S_HWR) begin
            mwe = 1'b1;
            hwe = 1'b1;
            if (found_reg) begin
                hwa = {tgt, srd};
                swd = nsl;
                cwd = cnt_sat;
            end else begin
                pwe = 1'b1;
                hwa = {tgt, SW'(0)};
                swd = (MAX_K == 1) ? '0 : SW'(1);
                cwd = CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg     <= lruk_pkg::K_RESET;
            clk_reg   <= '0;
            evtot_reg <= '0;
            valid_reg <= '0;
            ev_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (cfg_we) k_reg <= cfg_wdata;
            if (state_reg == S_DONE && (!mv_reg || m_ready)) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg     <= s_data;
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                        free_ok_reg <= 1'b0;
                        best_ok_reg <= 1'b0;
                        state_reg   <= (s_data.operation == lruk_pkg::OP_EVICT)
                                       ? S_EMETA : S_LOOK;
                    end
                end
                S_LOOK: begin
                    prev_reg <= idx;
                    idx_reg  <= idx_reg + 1'b1;
                    state_reg <= S_LOOKW;
                end
                S_LOOKW: begin
                    if (valid_reg[prev_reg] && prd == req_reg.page_number && !found_reg) begin
                        found_reg <= 1'b1;
                        hit_reg   <= prev_reg;
                    end
                    if (!valid_reg[prev_reg] && !free_ok_reg) begin
                        free_ok_reg <= 1'b1;
                        free_reg    <= prev_reg;
                    end
                    if (32'(idx_reg) >= ENTRIES) begin
                        state_reg <= S_DISP;
                    end else begin
                        prev_reg <= idx;
                        idx_reg  <= idx_reg + 1'b1;
                    end
                end
                S_DISP: begin
                    case (req_reg.operation)
                        lruk_pkg::OP_ACCESS: begin
                            if (!found_reg && !free_ok_reg) begin
                                st_reg    <= lruk_pkg::ST_FULL;
                                state_reg <= S_DONE;
                            end else if (clk_reg == CLK_MAX) begin
                                st_reg    <= lruk_pkg::ST_CLKSAT;
                                state_reg <= S_DONE;
                            end else begin
                                st_reg    <= lruk_pkg::ST_OK;
                                clk_reg   <= clk_reg + 1'b1;
                                state_reg <= S_HWR;
                                if (!found_reg) begin
                                    valid_reg[tgt] <= 1'b1;
                                    ev_reg[tgt]    <= 1'b1;
                                    evtot_reg      <= evtot_reg + 1'b1;
                                end
                            end
                        end
                        lruk_pkg::OP_SETEV: begin
                            state_reg <= S_DONE;
                            if (!found_reg) begin
                                st_reg <= lruk_pkg::ST_UNTRACK;
                            end else begin
                                st_reg <= lruk_pkg::ST_OK;
                                if (req_reg.evictable_flag && !ev_reg[hit_reg]) begin
                                    ev_reg[hit_reg] <= 1'b1;
                                    evtot_reg       <= evtot_reg + 1'b1;
                                end else if (!req_reg.evictable_flag && ev_reg[hit_reg]) begin
                                    ev_reg[hit_reg] <= 1'b0;
                                    evtot_reg       <= evtot_reg - 1'b1;
                                end
                            end
                        end
                        default: begin
                            state_reg <= S_DONE;
                            if (!found_reg || !ev_reg[hit_reg]) begin
                                st_reg <= lruk_pkg::ST_UNTRACK;
                            end else begin
                                st_reg             <= lruk_pkg::ST_OK;
                                valid_reg[hit_reg] <= 1'b0;
                                ev_reg[hit_reg]    <= 1'b0;
                                evtot_reg          <= evtot_reg - 1'b1;
                            end
                        end
                    endcase
                end
                S_HWR: state_reg <= S_DONE;
                S_EMETA: begin
                    if (32'(idx_reg) >= ENTRIES) begin
                        state_reg <= S_ECMP;
                    end else begin
                        cand_reg    <= idx;
                        cand_ok_reg <= valid_reg[idx] && ev_reg[idx];
                        idx_reg     <= idx_reg + 1'b1;
                        state_reg   <= S_EHIST;
                    end
                end
                S_EHIST: begin
                    cls_reg <= !infc;
                    if (cand_ok_reg) begin
                        prev_reg  <= cand_reg;
                        found_reg <= 1'b1;
                        state_reg <= S_ECMP;
                    end else begin
                        state_reg <= S_EMETA;
                    end
                end
                S_ECMP: begin
                    if (found_reg) begin
                        found_reg <= 1'b0;
                        if (better) begin
                            best_ok_reg  <= 1'b1;
                            best_cls_reg <= cls_reg;
                            best_ts_reg  <= hrd;
                            best_reg     <= prev_reg;
                        end
                        state_reg <= S_EMETA;
                    end else begin
                        state_reg <= S_DONE;
                        if (!best_ok_reg) begin
                            st_reg <= lruk_pkg::ST_NONE;
                        end else begin
                            st_reg              <= lruk_pkg::ST_OK;
                            valid_reg[best_reg] <= 1'b0;
                            ev_reg[best_reg]    <= 1'b0;
                            evtot_reg           <= evtot_reg - 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (!mv_reg || m_ready) begin
                        state_reg               <= S_IDLE;
                        rsp_reg.status          <= st_reg;
                        rsp_reg.evictable_count <= 7'(evtot_reg);
                        rsp_reg.victim_page     <= (req_reg.operation == lruk_pkg::OP_EVICT
                                                    && st_reg == lruk_pkg::ST_OK) ? prd : '0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = rsp_reg;
endmodule
`default_nettype wire

// ----- tb/sv/lru_k_page_replacer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_k_page_replacer_core_tb
// Self-checking bench: drives access/set-evictable/evict/remove beats with
// random idling on both sides, predicts each response from a behavioral
// model of the LRU-K table, and compares every response field by field.
// ----------------------------------------------------------------------------
module lru_k_page_replacer_core_tb;

    localparam int ENTRIES = 64;
    localparam int MAX_K   = 8;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [3:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    lruk_pkg::req_t s_data;
    logic m_valid;
    logic m_ready;
    lruk_pkg::rsp_t m_data;

    lru_k_page_replacer_core #(.ENTRIES(ENTRIES), .MAX_K(MAX_K), .CLOCK_BITS(32)) u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // model state
    logic [3:0]  mdl_k;
    bit          pg_valid [ENTRIES];
    logic [31:0] pg_num [ENTRIES];
    bit          pg_evict [ENTRIES];
    logic [31:0] pg_hist [ENTRIES][MAX_K];
    int          pg_cnt [ENTRIES];
    int          pg_slot [ENTRIES];
    logic [31:0] lru_clock;
    logic [6:0]  ev_total;

    lruk_pkg::req_t pending_reqs[$];
    lruk_pkg::rsp_t expected_rsps[$];
    int   errors;
    bit   quiet;
    int   s_gap;
    int   m_gap;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int find_page(input logic [31:0] p);
        for (int i = 0; i < ENTRIES; i++)
            if (pg_valid[i] && pg_num[i] == p) return i;
        return -1;
    endfunction

    function automatic int find_free();
        for (int i = 0; i < ENTRIES; i++)
            if (!pg_valid[i]) return i;
        return -1;
    endfunction

    function automatic lruk_pkg::rsp_t predict_replacer(input lruk_pkg::req_t r);
        lruk_pkg::rsp_t o;
        int e;
        int kk;
        int best;
        int bcls;
        logic [31:0] bts;
        int c;
        logic [31:0] t;
        e = find_page(r.page_number);
        o.status = lruk_pkg::ST_OK;
        o.victim_page = '0;
        case (r.operation)
            lruk_pkg::OP_ACCESS: begin
                if (e < 0 && find_free() < 0) o.status = lruk_pkg::ST_FULL;
                else if (lru_clock == 32'hFFFF_FFFF) o.status = lruk_pkg::ST_CLKSAT;
                else begin
                    lru_clock++;
                    if (e < 0) begin
                        e = find_free();
                        pg_valid[e] = 1; pg_num[e] = r.page_number; pg_evict[e] = 1;
                        pg_cnt[e] = 0; pg_slot[e] = 0; ev_total++;
                    end
                    pg_hist[e][pg_slot[e]] = lru_clock;
                    pg_slot[e] = (pg_slot[e] + 1) % MAX_K;
                    if (pg_cnt[e] < MAX_K) pg_cnt[e]++;
                end
            end
            lruk_pkg::OP_SETEV: begin
                if (e < 0) o.status = lruk_pkg::ST_UNTRACK;
                else if (r.evictable_flag && !pg_evict[e]) begin
                    pg_evict[e] = 1; ev_total++;
                end else if (!r.evictable_flag && pg_evict[e]) begin
                    pg_evict[e] = 0; ev_total--;
                end
            end
            lruk_pkg::OP_EVICT: begin
                kk = (mdl_k == 0) ? 1 : (mdl_k > MAX_K ? MAX_K : mdl_k);
                best = -1; bcls = 0; bts = '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!pg_valid[i] || !pg_evict[i]) continue;
                    if (pg_cnt[i] < kk) begin
                        c = 0; t = pg_hist[i][0];
                    end else begin
                        c = 1; t = pg_hist[i][(pg_slot[i] + MAX_K - kk) % MAX_K];
                    end
                    if (best < 0 || c < bcls || (c == bcls && t < bts)) begin
                        best = i; bcls = c; bts = t;
                    end
                end
                if (best < 0) o.status = lruk_pkg::ST_NONE;
                else begin
                    o.victim_page = pg_num[best];
                    pg_valid[best] = 0; pg_evict[best] = 0; ev_total--;
                end
            end
            default: begin
                if (e < 0 || !pg_evict[e]) o.status = lruk_pkg::ST_UNTRACK;
                else begin
                    pg_valid[e] = 0; pg_evict[e] = 0; ev_total--;
                end
            end
        endcase
        o.evictable_count = ev_total;
        return o;
    endfunction

    function automatic lruk_pkg::req_t make_req(input logic [1:0] op, input logic [31:0] p,
                                                input logic f);
        lruk_pkg::req_t r;
        r.operation = op; r.page_number = p; r.evictable_flag = f;
        return r;
    endfunction

    // page numbers from a small pool so lookups hit; occasional wide values
    function automatic logic [31:0] pick_page(input int pool);
        if ($urandom_range(0, 15) == 0) return $urandom();
        return 32'h0001_0000 + $urandom_range(0, pool - 1);
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            s_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && s_ready) begin
                expected_rsps.push_back(predict_replacer(s_data));
            end
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_valid <= 0;
            end else if (pending_reqs.size() > 0 && !cfg_we) begin
                s_data <= pending_reqs.pop_front();
                s_valid <= 1;
                if (!quiet && $urandom_range(0, 5) == 0) s_gap <= $urandom_range(1, 15);
            end else begin
                s_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
            m_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected response beat", 32'(m_data.status), '0);
                end else begin
                    lruk_pkg::rsp_t w;
                    w = expected_rsps.pop_front();
                    if (m_data.status !== w.status)
                        report_mismatch("status", 32'(m_data.status), 32'(w.status));
                    if (m_data.victim_page !== w.victim_page)
                        report_mismatch("victim_page", m_data.victim_page, w.victim_page);
                    if (m_data.evictable_count !== w.evictable_count)
                        report_mismatch("evictable_count", 32'(m_data.evictable_count),
                                        32'(w.evictable_count));
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_ready <= 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_gap <= $urandom_range(0, 14);
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_valid || expected_rsps.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_k(input logic [3:0] v);
        wait_idle();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        mdl_k = v;
        @(posedge aclk);
    endtask

    task automatic queue_random(input int n, input int pool);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                pending_reqs.push_back(make_req(lruk_pkg::OP_ACCESS, pick_page(pool),
                                                1'($urandom())));
            else if (sel < 65)
                pending_reqs.push_back(make_req(lruk_pkg::OP_SETEV, pick_page(pool),
                                                1'($urandom())));
            else if (sel < 85)
                pending_reqs.push_back(make_req(lruk_pkg::OP_EVICT, $urandom(),
                                                1'($urandom())));
            else
                pending_reqs.push_back(make_req(lruk_pkg::OP_REMOVE, pick_page(pool),
                                                1'($urandom())));
        end
    endtask

    initial begin
        logic [3:0] k_vals [6];
        aresetn = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        s_data = '0;
        errors = 0;
        quiet = 0;
        mdl_k = lruk_pkg::K_RESET;
        lru_clock = '0;
        ev_total = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            pg_valid[i] = 0; pg_evict[i] = 0;
        end
        k_vals = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd2};
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty evict, untracked ops, extremes, pinned paths
        pending_reqs.push_back(make_req(lruk_pkg::OP_EVICT, 32'h0, 1'b0));
        pending_reqs.push_back(make_req(lruk_pkg::OP_SETEV, 32'hFFFF_FFFF, 1'b1));
        pending_reqs.push_back(make_req(lruk_pkg::OP_REMOVE, 32'h0, 1'b0));
        pending_reqs.push_back(make_req(lruk_pkg::OP_ACCESS, 32'h0, 1'b0));
        pending_reqs.push_back(make_req(lruk_pkg::OP_ACCESS, 32'hFFFF_FFFF, 1'b1));
        pending_reqs.push_back(make_req(lruk_pkg::OP_ACCESS, 32'hFFFF_FFFF, 1'b0));
        pending_reqs.push_back(make_req(lruk_pkg::OP_SETEV, 32'h0, 1'b0));
        pending_reqs.push_back(make_req(lruk_pkg::OP_ACCESS, 32'h0, 1'b1));
        pending_reqs.push_back(make_req(lruk_pkg::OP_REMOVE, 32'h0, 1'b1));
        pending_reqs.push_back(make_req(lruk_pkg::OP_SETEV, 32'h0, 1'b0));
        pending_reqs.push_back(make_req(lruk_pkg::OP_SETEV, 32'h0, 1'b1));
        pending_reqs.push_back(make_req(lruk_pkg::OP_EVICT, 32'hFFFF_FFFF, 1'b1));
        pending_reqs.push_back(make_req(lruk_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b0));
        pending_reqs.push_back(make_req(lruk_pkg::OP_EVICT, 32'h0, 1'b0));
        pending_reqs.push_back(make_req(lruk_pkg::OP_EVICT, 32'h0, 1'b0));
        // fill the table past capacity
        for (int i = 0; i < ENTRIES + 2; i++)
            pending_reqs.push_back(make_req(lruk_pkg::OP_ACCESS, 32'h0002_0000 + i, 1'b0));
        pending_reqs.push_back(make_req(lruk_pkg::OP_ACCESS, 32'h0002_0000, 1'b0));
        for (int i = 0; i < ENTRIES + 1; i++)
            pending_reqs.push_back(make_req(lruk_pkg::OP_EVICT, 32'h0, 1'b0));

        // random phases across K settings, extremes included
        foreach (k_vals[j]) begin
            write_k(k_vals[j]);
            queue_random(110, (j % 2) ? 24 : 80);
        end
        wait_idle();
        quiet = 1;
        queue_random(100, 40);
        wait_idle();
        repeat (300) @(posedge aclk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lruk_pkg.sv
hw/rtl/lru_k_page_replacer_core.sv
tb/sv/lru_k_page_replacer_core_tb.sv
